[rtl/core/ksrsm_pkg.sv]
// Package for the k-smallest row-sum merge unit: payload structs,
// field widths, register indexes, state encoding and the saturating adder.
// No dependencies.
package ksrsm_pkg;

    localparam int VALUE_W = 20;
    localparam int SUM_W   = 32;
    localparam int CFG_W   = 11;

    // Configuration register indexes.
    localparam logic REG_ROW_LENGTH = 1'b0;
    localparam logic REG_KEEP_COUNT = 1'b1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               final_row;
    } ksrsm_in_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             last;
    } ksrsm_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COPY,
        ST_INIT_RD,
        ST_INIT_LAT,
        ST_INIT,
        ST_SCAN,
        ST_SCAN_END,
        ST_PICK,
        ST_ADV,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } ksrsm_state_t;

    // Adds a row value to a kept sum, saturating at the all-ones sum.
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b);
        logic [SUM_W:0] t;
        t = {1'b0, a} + (SUM_W+1)'(b);
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

endpackage

[rtl/core/ksrsm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ksrsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/ksrsm_sort_row.sv]
// Row of compare-and-shift cells that keeps the smallest values of the
// current row in ascending order. Depends on ksrsm_pkg.
module ksrsm_sort_row #(
    parameter int KEEP = 64
) (
    input  logic                                 clk,
    input  logic                                 ins,
    input  logic [ksrsm_pkg::VALUE_W-1:0]        ins_value,
    input  logic [$clog2(KEEP+1)-1:0]            held,
    input  logic                                 shift,
    output logic [ksrsm_pkg::VALUE_W-1:0]        head
);

    localparam int HW = $clog2(KEEP+1);

    logic [ksrsm_pkg::VALUE_W-1:0] cell_reg  [KEEP];
    logic [ksrsm_pkg::VALUE_W-1:0] cell_next [KEEP];

    // Each cell either keeps its value, takes the new value, or takes the
    // value of its left neighbor when the new value lands further left.
    // A shift moves every value one place toward the head.
    always_comb
    begin
        for (int p = 0; p < KEEP; p++)
        begin
            cell_next[p] = cell_reg[p];
            if (shift)
            begin
                if (p < KEEP-1)
                begin
                    cell_next[p] = cell_reg[p+1];
                end
            end
            else if (ins && (HW'(p) <= held)
                     && ((HW'(p) == held) || (cell_reg[p] > ins_value)))
            begin
                if ((p > 0) && (cell_reg[(p > 0) ? p-1 : 0] > ins_value))
                begin
                    cell_next[p] = cell_reg[(p > 0) ? p-1 : 0];
                end
                else
                begin
                    cell_next[p] = ins_value;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < KEEP; p++)
        begin
            cell_reg[p] <= cell_next[p];
        end
    end

    assign head = cell_reg[0];

endmodule

[rtl/core/k_smallest_row_sum_merge_unit.sv]
// Top level of the k-smallest row-sum merge unit.
// Depends on ksrsm_pkg, ksrsm_ram and ksrsm_sort_row.
//
// Matrix values enter on in_valid/in_ready, one per transaction, row by
// row. Sums leave on out_valid/out_ready in ascending order after the row
// flagged final_row completes; the last sum carries last. The register
// port (cfg_write, cfg_index, cfg_data) sets row_length and keep_count; the
// user must see that it is written only while the unit is idle, as the unit does not enforce this.
// Within a row each value is taken as it arrives; the cell row inserts it
// into the sorted list of the row's smallest values.
// At the end of the first row the kk smallest values are copied into the
// kept-sum memory. At the end of a later row the merge fills the candidate
// memory with one candidate per row value and then pops kk sums; each pop
// is a scan of the candidate memory through its read port, followed by a
// pick that advances or retires the chosen candidate.
// Each sum is read, loaded and presented in turn, and the unit waits while
// out_ready is low; a stalled output simply holds the unit until it is taken.
// Reset clears the control state and the register values to row_length
// 1024 and keep_count 64; the memories need no clearing pass.
module k_smallest_row_sum_merge_unit #(
    parameter int MAX_ROW  = 1024,
    parameter int MAX_KEEP = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ksrsm_pkg::ksrsm_in_t              in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ksrsm_pkg::ksrsm_out_t             out_item,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [ksrsm_pkg::CFG_W-1:0]       cfg_data
);

    localparam int CNT_W = $clog2(MAX_ROW+1);
    localparam int KW    = $clog2(MAX_KEEP+1);
    localparam int IW    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int VW    = ksrsm_pkg::VALUE_W;
    localparam int SW    = ksrsm_pkg::SUM_W;

    typedef struct packed {
        logic          alive;
        logic [IW-1:0] a;
        logic [VW-1:0] b;
        logic [SW-1:0] s;
    } cand_t;

    localparam int CAND_W = $bits(cand_t);

    ksrsm_pkg::ksrsm_state_t state_reg, state_next;

    logic [10:0]      rl_reg;
    logic [6:0]       kc_reg;
    logic [CNT_W-1:0] col_reg, col_next;
    logic             first_reg, first_next;
    logic             fin_reg, fin_next;
    logic             bank_reg, bank_next;
    logic [KW-1:0]    best_cnt_reg, best_cnt_next;
    logic [KW-1:0]    kk_reg, kk_next;
    logic [KW-1:0]    idx_reg, idx_next;
    logic [KW-1:0]    n_reg, n_next;
    logic             scan_v_reg, scan_v_next;
    logic [IW-1:0]    scan_j_reg, scan_j_next;
    logic             found_reg, found_next;
    logic [SW-1:0]    min_s_reg, min_s_next;
    logic [IW-1:0]    min_a_reg, min_a_next;
    logic [VW-1:0]    min_b_reg, min_b_next;
    logic [IW-1:0]    min_j_reg, min_j_next;
    logic [SW-1:0]    a0_reg, a0_next;
    logic             out_valid_reg, out_valid_next;
    ksrsm_pkg::ksrsm_out_t out_reg, out_next;

    // Memory ports.
    logic              best_we;
    logic [IW:0]       best_waddr, best_raddr;
    logic [SW-1:0]     best_wdata, best_rdata;
    logic              cand_we;
    logic [IW-1:0]     cand_waddr, cand_raddr;
    cand_t             cand_wdata, cand_rdata;
    logic [CAND_W-1:0] cand_rbits;

    // Sorting row controls.
    logic          row_ins, row_shift;
    logic [KW-1:0] held;
    logic [VW-1:0] head;

    // Row bookkeeping values.
    logic [31:0]    rl_eff, kc_eff, count32, kk32;
    logic [CNT_W-1:0] count;
    logic [KW:0]    a_inc;
    logic           pop_done;

    ksrsm_ram #(.WIDTH(SW), .DEPTH(2 ** (IW+1))) u_best_ram (
        .clk   (clk),
        .we    (best_we),
        .waddr (best_waddr),
        .wdata (best_wdata),
        .raddr (best_raddr),
        .rdata (best_rdata)
    );

    ksrsm_ram #(.WIDTH(CAND_W), .DEPTH(2 ** IW)) u_cand_ram (
        .clk   (clk),
        .we    (cand_we),
        .waddr (cand_waddr),
        .wdata (cand_wdata),
        .raddr (cand_raddr),
        .rdata (cand_rbits)
    );

    assign cand_rdata = cand_t'(cand_rbits);

    ksrsm_sort_row #(.KEEP(MAX_KEEP)) u_sort_row (
        .clk       (clk),
        .ins       (row_ins),
        .ins_value (in_item.value),
        .held      (held),
        .shift     (row_shift),
        .head      (head)
    );

    // Clamped register values and the row position of the incoming value.
    always_comb
    begin
        if (rl_reg == 11'd0)
        begin
            rl_eff = 32'd1;
        end
        else if (32'(rl_reg) > 32'(MAX_ROW))
        begin
            rl_eff = 32'(MAX_ROW);
        end
        else
        begin
            rl_eff = 32'(rl_reg);
        end
        if (kc_reg == 7'd0)
        begin
            kc_eff = 32'd1;
        end
        else if (32'(kc_reg) > 32'(MAX_KEEP))
        begin
            kc_eff = 32'(MAX_KEEP);
        end
        else
        begin
            kc_eff = 32'(kc_reg);
        end
        held    = (32'(col_reg) < 32'(MAX_KEEP)) ? KW'(col_reg) : KW'(MAX_KEEP);
        count   = col_reg + CNT_W'(1);
        count32 = 32'(count);
        kk32    = (kc_eff < count32) ? kc_eff : count32;
        a_inc   = (KW+1)'(min_a_reg) + (KW+1)'(1);
        pop_done = (n_reg == kk_reg - KW'(1));
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rl_reg <= 11'd1024;
            kc_reg <= 7'd64;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ksrsm_pkg::REG_ROW_LENGTH: rl_reg <= cfg_data;
                ksrsm_pkg::REG_KEEP_COUNT: kc_reg <= cfg_data[6:0];
                default: rl_reg <= rl_reg;
            endcase
        end
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ksrsm_pkg::ST_IDLE;
            col_reg       <= '0;
            first_reg     <= 1'b1;
            fin_reg       <= 1'b0;
            bank_reg      <= 1'b0;
            best_cnt_reg  <= '0;
            kk_reg        <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            scan_v_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            first_reg     <= first_next;
            fin_reg       <= fin_next;
            bank_reg      <= bank_next;
            best_cnt_reg  <= best_cnt_next;
            kk_reg        <= kk_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            scan_v_reg    <= scan_v_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        scan_j_reg <= scan_j_next;
        min_s_reg  <= min_s_next;
        min_a_reg  <= min_a_next;
        min_b_reg  <= min_b_next;
        min_j_reg  <= min_j_next;
        a0_reg     <= a0_next;
        out_reg    <= out_next;
    end

    // Next state, memory accesses and the running minimum of a scan.
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        first_next     = first_reg;
        fin_next       = fin_reg;
        bank_next      = bank_reg;
        best_cnt_next  = best_cnt_reg;
        kk_next        = kk_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        scan_v_next    = 1'b0;
        scan_j_next    = scan_j_reg;
        found_next     = found_reg;
        min_s_next     = min_s_reg;
        min_a_next     = min_a_reg;
        min_b_next     = min_b_reg;
        min_j_next     = min_j_reg;
        a0_next        = a0_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        in_ready       = 1'b0;
        row_ins        = 1'b0;
        row_shift      = 1'b0;
        best_we        = 1'b0;
        best_waddr     = {bank_reg, idx_reg[IW-1:0]};
        best_wdata     = SW'(head);
        best_raddr     = {bank_reg, idx_reg[IW-1:0]};
        cand_we        = 1'b0;
        cand_waddr     = idx_reg[IW-1:0];
        cand_wdata     = '{alive: 1'b1, a: '0, b: head,
                           s: ksrsm_pkg::sat_add(a0_reg, head)};
        cand_raddr     = idx_reg[IW-1:0];

        // Fold the candidate read last cycle into the running minimum.
        if (scan_v_reg && cand_rdata.alive
            && (!found_reg || (cand_rdata.s < min_s_reg)))
        begin
            found_next = 1'b1;
            min_s_next = cand_rdata.s;
            min_a_next = cand_rdata.a;
            min_b_next = cand_rdata.b;
            min_j_next = scan_j_reg;
        end

        unique case (state_reg)
            ksrsm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    row_ins = 1'b1;
                    if (count32 >= rl_eff)
                    begin
                        col_next   = '0;
                        kk_next    = KW'(kk32);
                        fin_next   = in_item.final_row;
                        idx_next   = '0;
                        n_next     = '0;
                        found_next = 1'b0;
                        state_next = first_reg ? ksrsm_pkg::ST_COPY
                                               : ksrsm_pkg::ST_INIT_RD;
                    end
                    else
                    begin
                        col_next = count;
                    end
                end
            end

            // First row: the smallest values become the kept sums.
            ksrsm_pkg::ST_COPY:
            begin
                best_we   = 1'b1;
                row_shift = 1'b1;
                idx_next  = idx_reg + KW'(1);
                if (idx_reg == kk_reg - KW'(1))
                begin
                    best_cnt_next = kk_reg;
                    first_next    = fin_reg;
                    idx_next      = '0;
                    state_next    = fin_reg ? ksrsm_pkg::ST_EMIT_RD
                                            : ksrsm_pkg::ST_IDLE;
                end
            end

            ksrsm_pkg::ST_INIT_RD:
            begin
                best_raddr = {bank_reg, IW'(0)};
                state_next = ksrsm_pkg::ST_INIT_LAT;
            end

            ksrsm_pkg::ST_INIT_LAT:
            begin
                a0_next    = best_rdata;
                state_next = ksrsm_pkg::ST_INIT;
            end

            // One candidate per row value, paired with the smallest kept sum.
            ksrsm_pkg::ST_INIT:
            begin
                cand_we   = 1'b1;
                row_shift = 1'b1;
                idx_next  = idx_reg + KW'(1);
                if (idx_reg == kk_reg - KW'(1))
                begin
                    idx_next   = '0;
                    state_next = ksrsm_pkg::ST_SCAN;
                end
            end

            ksrsm_pkg::ST_SCAN:
            begin
                scan_v_next = 1'b1;
                scan_j_next = idx_reg[IW-1:0];
                idx_next    = idx_reg + KW'(1);
                if (idx_reg == kk_reg - KW'(1))
                begin
                    state_next = ksrsm_pkg::ST_SCAN_END;
                end
            end

            ksrsm_pkg::ST_SCAN_END:
            begin
                state_next = ksrsm_pkg::ST_PICK;
            end

            // Take the minimum and advance its candidate to the next kept sum, or retire it when it has none.
            ksrsm_pkg::ST_PICK:
            begin
                best_we    = 1'b1;
                best_waddr = {~bank_reg, n_reg[IW-1:0]};
                best_wdata = min_s_reg;
                found_next = 1'b0;
                if (a_inc < (KW+1)'(best_cnt_reg))
                begin
                    best_raddr = {bank_reg, a_inc[IW-1:0]};
                    state_next = ksrsm_pkg::ST_ADV;
                end
                else
                begin
                    cand_we    = 1'b1;
                    cand_waddr = min_j_reg;
                    cand_wdata = '{alive: 1'b0, a: min_a_reg, b: min_b_reg,
                                   s: min_s_reg};
                    idx_next   = '0;
                    n_next     = n_reg + KW'(1);
                    state_next = ksrsm_pkg::ST_SCAN;
                    if (pop_done)
                    begin
                        bank_next     = ~bank_reg;
                        best_cnt_next = kk_reg;
                        first_next    = fin_reg;
                        state_next    = fin_reg ? ksrsm_pkg::ST_EMIT_RD
                                                : ksrsm_pkg::ST_IDLE;
                    end
                end
            end

            ksrsm_pkg::ST_ADV:
            begin
                cand_we    = 1'b1;
                cand_waddr = min_j_reg;
                cand_wdata = '{alive: 1'b1, a: a_inc[IW-1:0], b: min_b_reg,
                               s: ksrsm_pkg::sat_add(best_rdata, min_b_reg)};
                idx_next   = '0;
                n_next     = n_reg + KW'(1);
                state_next = ksrsm_pkg::ST_SCAN;
                if (pop_done)
                begin
                    bank_next     = ~bank_reg;
                    best_cnt_next = kk_reg;
                    first_next    = fin_reg;
                    state_next    = fin_reg ? ksrsm_pkg::ST_EMIT_RD
                                            : ksrsm_pkg::ST_IDLE;
                end
            end

            // Emission of the kept sums, one transaction at a time.
            ksrsm_pkg::ST_EMIT_RD:
            begin
                state_next = ksrsm_pkg::ST_EMIT_LD;
            end

            ksrsm_pkg::ST_EMIT_LD:
            begin
                out_next.sum   = best_rdata;
                out_next.last  = (idx_reg == best_cnt_reg - KW'(1));
                out_valid_next = 1'b1;
                state_next     = ksrsm_pkg::ST_EMIT_WAIT;
            end

            ksrsm_pkg::ST_EMIT_WAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    idx_next       = idx_reg + KW'(1);
                    state_next     = out_reg.last ? ksrsm_pkg::ST_IDLE
                                                  : ksrsm_pkg::ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = ksrsm_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

`ifndef NO_ASSERTIONS
    // A result is only presented while the emission waits for the receiver.
    a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == ksrsm_pkg::ST_EMIT_WAIT))
        else $error("result presented outside emission");

    // No input is taken while a result is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input accepted while a result is pending");

    // The kept list never outgrows its memory bank.
    a_best_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        32'(best_cnt_reg) <= 32'(MAX_KEEP))
        else $error("kept sum count out of range");

    // A pop always finds a live candidate.
    a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ksrsm_pkg::ST_PICK) |-> found_reg)
        else $error("merge pop without a live candidate");
`endif

endmodule

[verif/tb_k_smallest_row_sum_merge_unit.sv]
// Self-checking testbench for the k-smallest row-sum merge unit.
// Depends on ksrsm_pkg and k_smallest_row_sum_merge_unit; it models the kept
// sums of every matrix and checks each emitted sum in order.
module tb_k_smallest_row_sum_merge_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_CAP    = 1024;
    localparam int KEEP_CAP   = 64;
    localparam int STALL_LIMIT = 200000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    ksrsm_pkg::ksrsm_in_t          in_item;
    logic                          out_valid;
    logic                          out_ready;
    ksrsm_pkg::ksrsm_out_t         out_item;
    logic                          cfg_write;
    logic                          cfg_index;
    logic [ksrsm_pkg::CFG_W-1:0]   cfg_data;

    k_smallest_row_sum_merge_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with an 8 ns period.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state: configuration and matrix progress.
    logic [ksrsm_pkg::CFG_W-1:0]   pred_row_length;
    logic [6:0]                    pred_keep_count;
    logic [ksrsm_pkg::SUM_W-1:0]   kept_sums [KEEP_CAP];
    int unsigned                   kept_total;
    logic [ksrsm_pkg::VALUE_W-1:0] row_low [KEEP_CAP];
    int unsigned                   columns_seen;
    bit                            at_first_row;

    ksrsm_pkg::ksrsm_in_t  pending_items [$];
    ksrsm_pkg::ksrsm_out_t expected_sums [$];
    int         send_idle_pct;
    int         recv_stall_pct;
    bit         hold_output;
    int         mismatches;
    int         idle_cycles;

    function automatic logic [ksrsm_pkg::SUM_W-1:0] add_clamped(
        logic [ksrsm_pkg::SUM_W-1:0] a, logic [ksrsm_pkg::VALUE_W-1:0] b);
        logic [ksrsm_pkg::SUM_W:0] t;
        t = {1'b0, a} + {13'd0, b};
        return t[ksrsm_pkg::SUM_W] ? {ksrsm_pkg::SUM_W{1'b1}}
                                   : t[ksrsm_pkg::SUM_W-1:0];
    endfunction

    // Predicts the unit's response to one accepted value.
    task automatic predict_value(ksrsm_pkg::ksrsm_in_t it);
        int unsigned rl;
        int unsigned kc;
        int unsigned kk;
        int unsigned pos;
        int unsigned best_a;
        int unsigned used [KEEP_CAP];
        logic [ksrsm_pkg::SUM_W-1:0] merged [KEEP_CAP];
        logic [ksrsm_pkg::SUM_W-1:0] best_s;
        logic [ksrsm_pkg::SUM_W-1:0] s;
        ksrsm_pkg::ksrsm_out_t o;
        rl = 32'(pred_row_length);
        kc = 32'(pred_keep_count);
        if (rl < 1) rl = 1;
        if (rl > ROW_CAP) rl = ROW_CAP;
        if (kc < 1) kc = 1;
        if (kc > KEEP_CAP) kc = KEEP_CAP;
        // Insert into the sorted list of the row's smallest values.
        pos = (columns_seen < KEEP_CAP) ? columns_seen : KEEP_CAP;
        if (pos == KEEP_CAP)
        begin
            if (it.value >= row_low[KEEP_CAP-1]) pos = KEEP_CAP + 1;
            else pos = KEEP_CAP - 1;
        end
        if (pos <= KEEP_CAP - 1)
        begin
            while (pos > 0 && row_low[pos-1] > it.value)
            begin
                row_low[pos] = row_low[pos-1];
                pos--;
            end
            row_low[pos] = it.value;
        end
        columns_seen++;
        if (columns_seen < rl) return;
        kk = (kc < columns_seen) ? kc : columns_seen;
        if (at_first_row)
        begin
            for (int i = 0; i < kk; i++) kept_sums[i] = {12'd0, row_low[i]};
            at_first_row = 1'b0;
        end
        else
        begin
            // Multiway merge: one pointer into the kept list per row value.
            for (int j = 0; j < kk; j++) used[j] = 0;
            for (int n = 0; n < kk; n++)
            begin
                best_a = KEEP_CAP;
                best_s = '1;
                for (int j = 0; j < kk; j++)
                begin
                    if (used[j] < kept_total)
                    begin
                        s = add_clamped(kept_sums[used[j]], row_low[j]);
                        if (best_a == KEEP_CAP || s < best_s)
                        begin
                            best_s = s;
                            best_a = j;
                        end
                    end
                end
                merged[n] = best_s;
                used[best_a]++;
            end
            for (int n = 0; n < kk; n++) kept_sums[n] = merged[n];
        end
        kept_total = kk;
        columns_seen = 0;
        if (!it.final_row) return;
        for (int i = 0; i < kept_total; i++)
        begin
            o.sum  = kept_sums[i];
            o.last = (i + 1 == kept_total);
            expected_sums.insert(expected_sums.size(), o);
        end
        at_first_row = 1'b1;
    endtask

    // Driver: presents queued values and holds each until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else
        begin
            if (in_valid && in_ready) predict_value(in_item);
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_item  <= pending_items.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each sum transaction against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected sum %0d last %0b", out_item.sum, out_item.last);
                end
                else
                begin
                    ksrsm_pkg::ksrsm_out_t e;
                    e = expected_sums.pop_front();
                    if (e.sum !== out_item.sum || e.last !== out_item.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sum mismatch: expected %0d/%0b, got %0d/%0b",
                                     e.sum, e.last, out_item.sum, out_item.last);
                    end
                end
            end
            out_ready <= !hold_output && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_k_smallest_row_sum_merge_unit: FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(logic idx, int unsigned val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[ksrsm_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == ksrsm_pkg::REG_ROW_LENGTH) pred_row_length = val[ksrsm_pkg::CFG_W-1:0];
        else pred_keep_count = val[6:0];
    endtask

    // Waits until all queued values are taken and every sum has arrived.
    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_sums.size() > 0
               || columns_seen != 0)
        begin
            @(posedge clk);
        end
        // A merge without emission may still be running.
        repeat (20000) @(posedge clk);
    endtask

    // Queues one matrix of the given shape; pattern selects value style.
    task automatic queue_matrix(int rows, int cols, int pattern);
        ksrsm_pkg::ksrsm_in_t it;
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                case (pattern)
                    0: it.value = 20'($urandom_range(1048575));
                    1: it.value = 20'(20'hFFFFF - $urandom_range(3));
                    2: it.value = 20'($urandom_range(15));
                    default: it.value = $urandom_range(1) ? 20'hFFFFF : 20'h0;
                endcase
                it.final_row = (r == rows - 1);
                // A stray flag off the completing item must be ignored.
                if (c != cols - 1 && $urandom_range(7) == 0) it.final_row = ~it.final_row;
                pending_items.insert(pending_items.size(), it);
            end
        end
    endtask

    int rl_now;
    int kc_now;

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = ksrsm_pkg::REG_ROW_LENGTH;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_output = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        pred_row_length = 11'd1024;
        pred_keep_count = 7'd64;
        kept_total = 0;
        columns_seen = 0;
        at_first_row = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: single-value rows, zero and over-range registers, extremes of values.
        write_reg(ksrsm_pkg::REG_ROW_LENGTH, 0);
        write_reg(ksrsm_pkg::REG_KEEP_COUNT, 0);
        queue_matrix(3, 1, 3);
        drain();
        write_reg(ksrsm_pkg::REG_ROW_LENGTH, 4);
        write_reg(ksrsm_pkg::REG_KEEP_COUNT, 127);
        queue_matrix(3, 4, 1);
        drain();

        // Random matrices over several idle phases and settings.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 56; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 56;
                end
                default:
                begin
                    send_idle_pct = 23; recv_stall_pct = 23;
                end
            endcase
            for (int m = 0; m < 2; m++)
            begin
                rl_now = $urandom_range(1, 8);
                kc_now = $urandom_range(1, 10);
                write_reg(ksrsm_pkg::REG_ROW_LENGTH, rl_now);
                write_reg(ksrsm_pkg::REG_KEEP_COUNT, kc_now);
                queue_matrix($urandom_range(1, 3), rl_now, $urandom_range(3));
                drain();
            end
        end

        // Keep clamped to the row, with a long output hold-off while further values
        // wait to be sent.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(ksrsm_pkg::REG_ROW_LENGTH, 40);
        write_reg(ksrsm_pkg::REG_KEEP_COUNT, 64);
        queue_matrix(2, 40, 0);
        queue_matrix(1, 40, 2);
        hold_output = 1'b1;
        while (expected_sums.size() == 0) @(posedge clk);
        repeat (3000) @(posedge clk);
        hold_output = 1'b0;
        drain();

        if (mismatches == 0)
            $display("tb_k_smallest_row_sum_merge_unit: PASS");
        else
            $display("tb_k_smallest_row_sum_merge_unit: FAIL");
        $finish;
    end
endmodule
